[src/bsa_pkg.sv]
package bsa_pkg;

   localparam int MAX_SLOTS = 1024;
   localparam int WORD_BITS = 32;
   localparam int NUM_WORDS = (MAX_SLOTS + WORD_BITS - 1) / WORD_BITS;
   localparam int BIT_W     = $clog2(WORD_BITS);
   localparam int WADDR_W   = $clog2(NUM_WORDS);
   localparam int SLOT_W    = 10;
   localparam int CFG_W     = 11;

   typedef logic [WORD_BITS-1:0] word_type;

   typedef enum logic [1:0] {
      OP_ALLOC      = 2'd0,
      OP_FREE       = 2'd1,
      OP_ITER_START = 2'd2,
      OP_ITER_NEXT  = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_ALLOC,
      ST_FREE,
      ST_ITER
   } state_type;

   typedef struct packed {
      logic [1:0]        req_type;
      logic [SLOT_W-1:0] free_slot;
   } req_payload_type;

   typedef struct packed {
      logic [SLOT_W-1:0] slot_index;
      logic              found;
   } rsp_payload_type;

   typedef struct packed {
      logic               rd_en;
      logic [WADDR_W-1:0] rd_addr;
      logic               wr_en;
      logic [WADDR_W-1:0] wr_addr;
      word_type           wr_data;
   } mem_cmd_type;

   function automatic logic [CFG_W-1:0] eff_slots(logic [CFG_W-1:0] s);
      return (s > CFG_W'(MAX_SLOTS)) ? CFG_W'(MAX_SLOTS) : s;
   endfunction

   // bits of word w whose slots lie below n
   function automatic word_type word_mask(logic [WADDR_W-1:0] w, logic [CFG_W-1:0] n);
      logic [CFG_W-1:0] base;
      logic [CFG_W-1:0] rem;
      word_type         m;
      base = CFG_W'(w) << BIT_W;
      rem  = n - base;
      if (base >= n) begin
         m = '0;
      end else if (rem >= CFG_W'(WORD_BITS)) begin
         m = '1;
      end else begin
         m = (word_type'(1) << rem[BIT_W-1:0]) - word_type'(1);
      end
      return m;
   endfunction

   function automatic logic [BIT_W-1:0] lowest_bit(word_type v);
      logic [BIT_W-1:0] idx;
      idx = '0;
      for (int i = WORD_BITS - 1; i >= 0; i--) begin
         if (v[i]) begin
            idx = BIT_W'(i);
         end
      end
      return idx;
   endfunction

endpackage

[src/bsa_map_ram.sv]
module bsa_map_ram (
   input  logic                 clock,
   input  logic                 reset,
   input  bsa_pkg::mem_cmd_type mem_cmd,
   output bsa_pkg::word_type    rd_data
);

   bsa_pkg::word_type                 map_mem [bsa_pkg::NUM_WORDS];
   logic [bsa_pkg::NUM_WORDS-1:0]     valid_ff;
   bsa_pkg::word_type                 rd_word_ff;
   logic                              rd_valid_ff;

   always_ff @(posedge clock) begin
      if (mem_cmd.wr_en) begin
         map_mem[mem_cmd.wr_addr] <= mem_cmd.wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_cmd.rd_en) begin
         rd_word_ff <= map_mem[mem_cmd.rd_addr];
      end
   end

   // a word never written since reset reads as all free
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         if (mem_cmd.wr_en) begin
            valid_ff[mem_cmd.wr_addr] <= 1'b1;
         end
         if (mem_cmd.rd_en) begin
            rd_valid_ff <= valid_ff[mem_cmd.rd_addr];
         end
      end
   end

   assign rd_data = rd_valid_ff ? rd_word_ff : '0;

endmodule

[src/bsa_ctrl.sv]
module bsa_ctrl (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  bsa_pkg::req_payload_type      req,
   output logic                          busy,
   output logic                          rsp_strobe,
   output bsa_pkg::rsp_payload_type      rsp,
   input  logic [bsa_pkg::CFG_W-1:0]     slots_in_use,
   output bsa_pkg::mem_cmd_type          mem_cmd,
   input  bsa_pkg::word_type             rd_data
);

   bsa_pkg::state_type              state_ff, state_in;
   logic [bsa_pkg::WADDR_W-1:0]     start_word_ff, start_word_in;
   logic [bsa_pkg::WADDR_W-1:0]     scan_word_ff, scan_word_in;
   logic [bsa_pkg::CFG_W-1:0]       cursor_ff, cursor_in;
   logic [bsa_pkg::SLOT_W-1:0]      free_slot_ff, free_slot_in;
   logic                            rsp_valid_ff, rsp_valid_in;
   bsa_pkg::rsp_payload_type        rsp_ff, rsp_in;

   logic [bsa_pkg::CFG_W-1:0]       n_eff;
   bsa_pkg::op_type                 op;
   logic                            free_ok;
   logic [bsa_pkg::CFG_W-1:0]       iter_pos;
   logic                            iter_ok;
   bsa_pkg::word_type               alloc_avail;
   bsa_pkg::word_type               iter_set;
   logic                            alloc_hit;
   logic                            iter_hit;
   logic [bsa_pkg::BIT_W-1:0]       pick_bit;
   logic                            last_word;
   logic [bsa_pkg::WADDR_W-1:0]     iter_word;
   logic [bsa_pkg::CFG_W-1:0]       next_base;
   logic                            iter_end;
   logic [bsa_pkg::SLOT_W-1:0]      iter_slot;

   always_comb begin
      n_eff       = bsa_pkg::eff_slots(slots_in_use);
      op          = bsa_pkg::op_type'(req.req_type);
      free_ok     = {1'b0, req.free_slot} < n_eff;
      iter_pos    = (op == bsa_pkg::OP_ITER_START) ? '0 : cursor_ff;
      iter_ok     = iter_pos < n_eff;
      alloc_avail = ~rd_data & bsa_pkg::word_mask(scan_word_ff, n_eff);
      iter_word   = cursor_ff[bsa_pkg::SLOT_W-1:bsa_pkg::BIT_W];
      iter_set    = rd_data & bsa_pkg::word_mask(iter_word, n_eff)
                    & ('1 << cursor_ff[bsa_pkg::BIT_W-1:0]);
      alloc_hit   = |alloc_avail;
      iter_hit    = |iter_set;
      pick_bit    = bsa_pkg::lowest_bit((state_ff == bsa_pkg::ST_ITER) ? iter_set
                                                                       : alloc_avail);
      last_word   = scan_word_ff == bsa_pkg::WADDR_W'(bsa_pkg::NUM_WORDS - 1);
      next_base   = (bsa_pkg::CFG_W'(iter_word) + bsa_pkg::CFG_W'(1)) << bsa_pkg::BIT_W;
      iter_end    = next_base >= n_eff;
      iter_slot   = {iter_word, pick_bit};
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         bsa_pkg::ST_IDLE: begin
            if (start) begin
               case (op)
                  bsa_pkg::OP_ALLOC: state_in = bsa_pkg::ST_ALLOC;
                  bsa_pkg::OP_FREE: begin
                     if (free_ok) state_in = bsa_pkg::ST_FREE;
                  end
                  bsa_pkg::OP_ITER_START, bsa_pkg::OP_ITER_NEXT: begin
                     if (iter_ok) state_in = bsa_pkg::ST_ITER;
                  end
                  default: state_in = bsa_pkg::ST_IDLE;
               endcase
            end
         end
         bsa_pkg::ST_ALLOC: begin
            if (alloc_hit || (last_word && start_word_ff == '0)) state_in = bsa_pkg::ST_IDLE;
         end
         bsa_pkg::ST_FREE: state_in = bsa_pkg::ST_IDLE;
         bsa_pkg::ST_ITER: begin
            if (iter_hit || iter_end) state_in = bsa_pkg::ST_IDLE;
         end
         default: state_in = bsa_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      mem_cmd       = '0;
      start_word_in = start_word_ff;
      scan_word_in  = scan_word_ff;
      cursor_in     = cursor_ff;
      free_slot_in  = free_slot_ff;
      rsp_valid_in  = 1'b0;
      rsp_in        = '0;
      case (state_ff)
         bsa_pkg::ST_IDLE: begin
            if (start) begin
               case (op)
                  bsa_pkg::OP_ALLOC: begin
                     mem_cmd.rd_en   = 1'b1;
                     mem_cmd.rd_addr = start_word_ff;
                     scan_word_in    = start_word_ff;
                  end
                  bsa_pkg::OP_FREE: begin
                     if (free_ok) begin
                        mem_cmd.rd_en   = 1'b1;
                        mem_cmd.rd_addr = req.free_slot[bsa_pkg::SLOT_W-1:bsa_pkg::BIT_W];
                        free_slot_in    = req.free_slot;
                     end else begin
                        rsp_valid_in = 1'b1;
                     end
                  end
                  bsa_pkg::OP_ITER_START, bsa_pkg::OP_ITER_NEXT: begin
                     cursor_in = iter_pos;
                     if (iter_ok) begin
                        mem_cmd.rd_en   = 1'b1;
                        mem_cmd.rd_addr = iter_pos[bsa_pkg::SLOT_W-1:bsa_pkg::BIT_W];
                     end else begin
                        rsp_valid_in = 1'b1;
                     end
                  end
                  default: ;
               endcase
            end
         end
         bsa_pkg::ST_ALLOC: begin
            if (alloc_hit) begin
               mem_cmd.wr_en   = 1'b1;
               mem_cmd.wr_addr = scan_word_ff;
               mem_cmd.wr_data = rd_data | (bsa_pkg::word_type'(1) << pick_bit);
               start_word_in   = scan_word_ff;
               rsp_valid_in    = 1'b1;
               rsp_in          = '{slot_index: {scan_word_ff, pick_bit}, found: 1'b1};
            end else if (last_word) begin
               // wrap once to word 0 unless this pass already started there
               if (start_word_ff != '0) begin
                  start_word_in   = '0;
                  scan_word_in    = '0;
                  mem_cmd.rd_en   = 1'b1;
                  mem_cmd.rd_addr = '0;
               end else begin
                  rsp_valid_in = 1'b1;
               end
            end else begin
               // next word is read while this one is checked
               scan_word_in    = scan_word_ff + 1'b1;
               mem_cmd.rd_en   = 1'b1;
               mem_cmd.rd_addr = scan_word_ff + 1'b1;
            end
         end
         bsa_pkg::ST_FREE: begin
            mem_cmd.wr_en   = 1'b1;
            mem_cmd.wr_addr = free_slot_ff[bsa_pkg::SLOT_W-1:bsa_pkg::BIT_W];
            mem_cmd.wr_data = rd_data
                              & ~(bsa_pkg::word_type'(1) << free_slot_ff[bsa_pkg::BIT_W-1:0]);
            rsp_valid_in    = 1'b1;
            rsp_in          = '{slot_index: free_slot_ff, found: 1'b1};
         end
         bsa_pkg::ST_ITER: begin
            if (iter_hit) begin
               cursor_in    = bsa_pkg::CFG_W'(iter_slot) + bsa_pkg::CFG_W'(1);
               rsp_valid_in = 1'b1;
               rsp_in       = '{slot_index: iter_slot, found: 1'b1};
            end else if (iter_end) begin
               cursor_in    = n_eff;
               rsp_valid_in = 1'b1;
            end else begin
               cursor_in       = next_base;
               mem_cmd.rd_en   = 1'b1;
               mem_cmd.rd_addr = iter_word + 1'b1;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= bsa_pkg::ST_IDLE;
         start_word_ff <= '0;
         cursor_ff     <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         start_word_ff <= start_word_in;
         cursor_ff     <= cursor_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      scan_word_ff <= scan_word_in;
      free_slot_ff <= free_slot_in;
      rsp_ff       <= rsp_in;
   end

   assign busy       = state_ff != bsa_pkg::ST_IDLE;
   assign rsp_strobe = rsp_valid_ff;
   assign rsp        = rsp_ff;

endmodule

[src/bitmap_slot_allocator.sv]
// Next-fit slot allocator over a 1024-slot bitmap held in a 32 x 32-bit memory.
// Request channel: a beat is taken when start is high and busy is low; req_data
// carries the op (allocate, free, iterate from start, iterate next) and the slot
// to free. Every request gives exactly one response beat: rsp_strobe is high for
// one cycle with rsp_data (slot_index, found). The receiver cannot stall, so the
// response is simply presented for that cycle.
// Timing: the bitmap memory port handles one word per cycle. A scanning request
// reads bitmap words one after another before it strobes its response (allocate:
// words from the roving start word, up to 63 with the wrap; iterate: words from the
// cursor, up to 32). Free reads the slot's word on acceptance and writes it back in
// ST_FREE. Requests that fail on their range check respond in the cycle after
// acceptance. busy drops in the response cycle, so a new request may be taken then.
// CSR channel: csr_wdata sets slots_in_use (reset 1024); accepted while idle and
// no request is presented.
// Reset: synchronous, active high; the bitmap reads as all free right away (per
// word valid bits), start word and iteration cursor go to 0.
module bitmap_slot_allocator (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   output logic                           busy,
   input  bsa_pkg::req_payload_type       req_data,
   output logic                           rsp_strobe,
   output bsa_pkg::rsp_payload_type       rsp_data,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [bsa_pkg::CFG_W-1:0]      csr_wdata
);

   logic [bsa_pkg::CFG_W-1:0] slots_in_use_ff;
   bsa_pkg::mem_cmd_type      mem_cmd;
   bsa_pkg::word_type         rd_data;

   assign csr_ready = ~busy & ~start;

   always_ff @(posedge clock) begin
      if (reset) begin
         slots_in_use_ff <= bsa_pkg::CFG_W'(bsa_pkg::MAX_SLOTS);
      end else if (csr_valid && csr_ready) begin
         slots_in_use_ff <= csr_wdata;
      end
   end

   bsa_ctrl u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .req          (req_data),
      .busy         (busy),
      .rsp_strobe   (rsp_strobe),
      .rsp          (rsp_data),
      .slots_in_use (slots_in_use_ff),
      .mem_cmd      (mem_cmd),
      .rd_data      (rd_data)
   );

   bsa_map_ram u_map_ram (
      .clock   (clock),
      .reset   (reset),
      .mem_cmd (mem_cmd),
      .rd_data (rd_data)
   );

   // a failed beat never carries a slot number
   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_data.found |-> rsp_data.slot_index == '0)
      else $error("failed response with nonzero slot");

   // any reported slot lies below the managed count
   a_slot_range: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_data.found |->
         {1'b0, rsp_data.slot_index} < bsa_pkg::eff_slots(slots_in_use_ff))
      else $error("reported slot out of range");

   // the response beat coincides with the return to idle
   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !busy)
      else $error("response while still busy");

   // a response only follows work in flight or a request just taken
   a_rsp_cause: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(busy) || $past(start))
      else $error("response without request");

   // the memory is never written while idle with no request
   a_no_idle_write: assert property (@(posedge clock) disable iff (reset)
      !busy && !start |-> !mem_cmd.wr_en)
      else $error("bitmap write while idle");

endmodule
